@@ rtl/core/crt_pkg.sv @@
// Shared types, codes and helper functions of the compaction relocation table.
package crt_pkg;

  // Request codes as they arrive on req_type
  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_NOTE  = 2'd1,
    REQ_CLOSE = 2'd2,
    REQ_MAP   = 2'd3
  } req_op_t;

  // Result kinds
  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_MOVE    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_MAP     = 2'd3;

  localparam logic [15:0] POOL_RESET = 16'd16384;
  localparam int unsigned REQ_W = 52;

  typedef struct packed {
    req_op_t     op;
    logic        first_round;
    logic        full_pass;
    logic [15:0] heap_top;
    logic [15:0] chunk_offset;
    logic [15:0] chunk_size;
  } crt_req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] move_from;
    logic [15:0] move_to;
    logic [15:0] move_bytes;
    logic        map_found;
    logic        last_result;
    logic [15:0] new_top;
    logic [15:0] free_bytes;
    logic        more_rounds;
  } crt_res_t;

  localparam int unsigned RES_W = $bits(crt_res_t);

  // Sequencer states of the back part
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NOTE_TOP_RD,
    ST_NOTE_TOP_CHK,
    ST_NOTE_STEP,
    ST_NOTE_CHK,
    ST_NOTE_DONE,
    ST_NOTE_HI,
    ST_CLOSE_NEXT,
    ST_CLOSE_SKIP,
    ST_MOVE_RD,
    ST_MOVE_EMIT,
    ST_MAP_NEXT,
    ST_MAP_CHK,
    ST_EMIT
  } crt_state_t;

  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] free_calc(input logic [15:0] pool, input logic [15:0] top);
    return (top < pool) ? (pool - top) : 16'd0;
  endfunction

  function automatic crt_res_t mk_res(input logic [1:0] kind, input logic [15:0] from,
                                      input logic [15:0] to, input logic [15:0] bytes,
                                      input logic found, input logic last,
                                      input logic [15:0] top, input logic [15:0] freeb,
                                      input logic more);
    crt_res_t r;
    r.result_kind = kind;
    r.move_from   = from;
    r.move_to     = to;
    r.move_bytes  = bytes;
    r.map_found   = found;
    r.last_result = last;
    r.new_top     = top;
    r.free_bytes  = freeb;
    r.more_rounds = more;
    return r;
  endfunction

endpackage

@@ rtl/core/crt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module crt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/crt_fifo.sv @@
// Small synchronous FIFO used for the request and result queues.
module crt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    fill;
  logic             do_push;
  logic             do_pop;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (!do_push && do_pop) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/crt_front.sv @@
// Front part: queues incoming requests and decodes them for the sequencer.
module crt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          req_type,
  input  logic                first_round,
  input  logic                full_pass,
  input  logic [15:0]         heap_top,
  input  logic [15:0]         chunk_offset,
  input  logic [15:0]         chunk_size,
  input  logic                take,
  output logic                req_valid,
  output crt_pkg::crt_req_t   req
);

  logic [crt_pkg::REQ_W-1:0] wdata;
  logic [crt_pkg::REQ_W-1:0] rdata;
  logic                      empty;

  assign wdata = {req_type, first_round, full_pass, heap_top, chunk_offset, chunk_size};

  crt_fifo #(
    .WIDTH (crt_pkg::REQ_W),
    .DEPTH (2)
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (take),
    .rdata (rdata),
    .empty (empty)
  );

  // classify the oldest request
  always_comb begin
    req_valid        = !empty;
    req.op           = crt_pkg::req_op_t'(rdata[51:50]);
    req.first_round  = rdata[49];
    req.full_pass    = rdata[48];
    req.heap_top     = rdata[47:32];
    req.chunk_offset = rdata[31:16];
    req.chunk_size   = rdata[15:0];
  end

endmodule

@@ rtl/core/crt_back.sv @@
// Back part: sequencer that owns the sorted chunk table and produces results.
module crt_back #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [15:0]        cfg_data,
  input  logic               req_valid,
  input  crt_pkg::crt_req_t  req,
  output logic               take,
  input  logic               res_full,
  output logic               res_push,
  output crt_pkg::crt_res_t  res_out
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] LAST_IDX = CW'(TABLE_ENTRIES - 1);

  crt_pkg::crt_state_t state, state_next;
  crt_pkg::crt_req_t   cur, cur_next;
  crt_pkg::crt_res_t   res, res_next;
  logic [CW-1:0]       idx, idx_next;
  logic [15:0]         top, top_next;
  logic [CW-1:0]       entry_count, entry_count_next;
  logic [CW-1:0]       first_moving, first_moving_next;
  logic [15:0]         window_low, window_low_next;
  logic [15:0]         window_high, window_high_next;
  logic [15:0]         running_top, running_top_next;
  logic [15:0]         last_full_top, last_full_top_next;
  logic                pass_is_full, pass_is_full_next;
  logic                closed, closed_next;
  logic [15:0]         pool_bytes;

  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [31:0]         ram_wdata;
  logic [31:0]         rd_data;
  logic [15:0]         rd_old;
  logic [15:0]         rd_size;
  logic [CW-1:0]       idx_dec;
  logic [CW-1:0]       idx_inc;
  logic [CW-1:0]       cnt_inc;
  logic                more;
  logic                full_sel;
  logic [15:0]         start_top;
  logic [15:0]         move_top;

  assign rd_old  = rd_data[31:16];
  assign rd_size = rd_data[15:0];
  assign idx_dec = idx - CW'(1);
  assign idx_inc = idx + CW'(1);
  assign cnt_inc = (entry_count == FULL_CNT) ? entry_count : entry_count + CW'(1);
  assign more    = (entry_count == FULL_CNT);
  assign move_top = crt_pkg::sat_add(top, rd_size);

  // table storage: {old offset, size or new offset}
  crt_ram #(
    .WIDTH (32),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= crt_pkg::ST_IDLE;
      entry_count   <= '0;
      first_moving  <= '0;
      window_low    <= '0;
      window_high   <= '0;
      running_top   <= '0;
      last_full_top <= '0;
      pass_is_full  <= 1'b0;
      closed        <= 1'b0;
      pool_bytes    <= crt_pkg::POOL_RESET;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      first_moving  <= first_moving_next;
      window_low    <= window_low_next;
      window_high   <= window_high_next;
      running_top   <= running_top_next;
      last_full_top <= last_full_top_next;
      pass_is_full  <= pass_is_full_next;
      closed        <= closed_next;
      if (cfg_valid) begin
        pool_bytes <= cfg_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    res <= res_next;
    idx <= idx_next;
    top <= top_next;
  end

  // sequencer
  always_comb begin
    state_next         = state;
    cur_next           = cur;
    res_next           = res;
    idx_next           = idx;
    top_next           = top;
    entry_count_next   = entry_count;
    first_moving_next  = first_moving;
    window_low_next    = window_low;
    window_high_next   = window_high;
    running_top_next   = running_top;
    last_full_top_next = last_full_top;
    pass_is_full_next  = pass_is_full;
    closed_next        = closed;
    take               = 1'b0;
    res_push           = 1'b0;
    res_out            = res;
    ram_re             = 1'b0;
    ram_raddr          = idx[AW-1:0];
    ram_we             = 1'b0;
    ram_waddr          = idx[AW-1:0];
    ram_wdata          = {cur.chunk_offset, cur.chunk_size};
    full_sel           = 1'b0;
    start_top          = running_top;

    case (state)
      crt_pkg::ST_IDLE: begin
        if (req_valid) begin
          take     = 1'b1;
          cur_next = req;
          case (req.op)
            crt_pkg::REQ_START: begin
              if (req.first_round) begin
                full_sel          = req.full_pass || (last_full_top == 16'd0);
                pass_is_full_next = full_sel;
                start_top         = full_sel ? 16'd0 : last_full_top;
                running_top_next  = start_top;
                window_low_next   = start_top;
              end else begin
                window_low_next = window_high;
              end
              window_high_next  = req.heap_top;
              entry_count_next  = '0;
              first_moving_next = '0;
              closed_next       = 1'b0;
              res_next = crt_pkg::mk_res(crt_pkg::KIND_ACK, '0, '0, '0, 1'b0, 1'b1,
                                         start_top, '0, 1'b0);
              state_next = crt_pkg::ST_EMIT;
            end
            crt_pkg::REQ_NOTE: begin
              res_next = crt_pkg::mk_res(crt_pkg::KIND_ACK, '0, '0, '0, 1'b0, 1'b1,
                                         running_top, '0, 1'b0);
              if (closed || req.chunk_offset < window_low ||
                  req.chunk_offset >= window_high) begin
                state_next = crt_pkg::ST_EMIT;
              end else if (entry_count == FULL_CNT) begin
                idx_next   = LAST_IDX;
                state_next = crt_pkg::ST_NOTE_TOP_RD;
              end else begin
                idx_next   = entry_count;
                state_next = crt_pkg::ST_NOTE_STEP;
              end
            end
            crt_pkg::REQ_CLOSE: begin
              if (closed) begin
                res_next = crt_pkg::mk_res(crt_pkg::KIND_SUMMARY, '0, '0, '0, 1'b0, 1'b1,
                                           running_top,
                                           crt_pkg::free_calc(pool_bytes, running_top),
                                           more);
                state_next = crt_pkg::ST_EMIT;
              end else begin
                top_next   = running_top;
                idx_next   = '0;
                state_next = crt_pkg::ST_CLOSE_NEXT;
              end
            end
            default: begin
              // map request
              res_next = crt_pkg::mk_res(crt_pkg::KIND_MAP, '0, req.chunk_offset, '0,
                                         1'b0, 1'b1, running_top, '0, 1'b0);
              if (!closed) begin
                state_next = crt_pkg::ST_EMIT;
              end else if (req.chunk_offset < window_low ||
                           req.chunk_offset >= window_high) begin
                res_next.map_found = 1'b1;
                state_next         = crt_pkg::ST_EMIT;
              end else begin
                idx_next   = first_moving;
                state_next = crt_pkg::ST_MAP_NEXT;
              end
            end
          endcase
        end
      end

      // full table: a note past the last entry is dropped
      crt_pkg::ST_NOTE_TOP_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = LAST_IDX[AW-1:0];
        state_next = crt_pkg::ST_NOTE_TOP_CHK;
      end
      crt_pkg::ST_NOTE_TOP_CHK: begin
        state_next = (rd_old < cur.chunk_offset) ? crt_pkg::ST_EMIT : crt_pkg::ST_NOTE_STEP;
      end

      // insertion walk from the top down, shifting entries not below the new offset up
      crt_pkg::ST_NOTE_STEP: begin
        if (idx == '0) begin
          ram_we     = 1'b1;
          state_next = crt_pkg::ST_NOTE_DONE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = idx_dec[AW-1:0];
          state_next = crt_pkg::ST_NOTE_CHK;
        end
      end
      crt_pkg::ST_NOTE_CHK: begin
        ram_we = 1'b1;
        if (rd_old >= cur.chunk_offset) begin
          ram_wdata  = rd_data;
          idx_next   = idx_dec;
          state_next = crt_pkg::ST_NOTE_STEP;
        end else begin
          state_next = crt_pkg::ST_NOTE_DONE;
        end
      end
      crt_pkg::ST_NOTE_DONE: begin
        entry_count_next = cnt_inc;
        if (cnt_inc == FULL_CNT) begin
          ram_re     = 1'b1;
          ram_raddr  = LAST_IDX[AW-1:0];
          state_next = crt_pkg::ST_NOTE_HI;
        end else begin
          state_next = crt_pkg::ST_EMIT;
        end
      end
      crt_pkg::ST_NOTE_HI: begin
        window_high_next = crt_pkg::sat_add(rd_old, rd_size);
        state_next       = crt_pkg::ST_EMIT;
      end

      // close: skip chunks already in place
      crt_pkg::ST_CLOSE_NEXT: begin
        if (idx == entry_count) begin
          first_moving_next = idx;
          window_low_next   = window_high;
          running_top_next  = top;
          closed_next       = 1'b1;
          if (!more && pass_is_full) begin
            last_full_top_next = top;
          end
          res_next = crt_pkg::mk_res(crt_pkg::KIND_SUMMARY, '0, '0, '0, 1'b0, 1'b1, top,
                                     crt_pkg::free_calc(pool_bytes, top), more);
          state_next = crt_pkg::ST_EMIT;
        end else begin
          ram_re     = 1'b1;
          state_next = crt_pkg::ST_CLOSE_SKIP;
        end
      end
      crt_pkg::ST_CLOSE_SKIP: begin
        if (rd_old > top) begin
          first_moving_next = idx;
          window_low_next   = rd_old;
          state_next        = crt_pkg::ST_MOVE_EMIT;
        end else begin
          top_next   = crt_pkg::sat_add(top, rd_size);
          idx_next   = idx_inc;
          state_next = crt_pkg::ST_CLOSE_NEXT;
        end
      end

      // close: assign new offsets and emit moves
      crt_pkg::ST_MOVE_RD: begin
        ram_re     = 1'b1;
        state_next = crt_pkg::ST_MOVE_EMIT;
      end
      crt_pkg::ST_MOVE_EMIT: begin
        res_out = crt_pkg::mk_res(crt_pkg::KIND_MOVE, rd_old, top, rd_size, 1'b0, 1'b0,
                                  move_top, '0, 1'b0);
        if (idx_inc == entry_count) begin
          res_out.last_result = 1'b1;
          res_out.free_bytes  = crt_pkg::free_calc(pool_bytes, move_top);
          res_out.more_rounds = more;
        end
        if (!res_full) begin
          res_push  = 1'b1;
          ram_we    = 1'b1;
          ram_wdata = {rd_old, top};
          top_next  = move_top;
          idx_next  = idx_inc;
          if (idx_inc == entry_count) begin
            running_top_next = move_top;
            closed_next      = 1'b1;
            if (!more && pass_is_full) begin
              last_full_top_next = move_top;
            end
            state_next = crt_pkg::ST_IDLE;
          end else begin
            state_next = crt_pkg::ST_MOVE_RD;
          end
        end
      end

      // map: walk to the first entry not below the key
      crt_pkg::ST_MAP_NEXT: begin
        if (idx == entry_count) begin
          state_next = crt_pkg::ST_EMIT;
        end else begin
          ram_re     = 1'b1;
          state_next = crt_pkg::ST_MAP_CHK;
        end
      end
      crt_pkg::ST_MAP_CHK: begin
        if (rd_old >= cur.chunk_offset) begin
          if (rd_old == cur.chunk_offset) begin
            res_next.move_to   = rd_size;
            res_next.map_found = 1'b1;
          end
          state_next = crt_pkg::ST_EMIT;
        end else begin
          idx_next   = idx_inc;
          state_next = crt_pkg::ST_MAP_NEXT;
        end
      end

      crt_pkg::ST_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = crt_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = crt_pkg::ST_IDLE;
      end
    endcase
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count beyond table size");

  a_first_moving: assert property (@(posedge clk) disable iff (rst)
    first_moving <= entry_count)
    else $error("first moving index beyond entry count");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_take_idle: assert property (@(posedge clk) disable iff (rst)
    take |-> (state == crt_pkg::ST_IDLE && req_valid))
    else $error("request taken while busy");

  a_note_open: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != crt_pkg::ST_MOVE_EMIT) |-> !closed)
    else $error("table insert after close");

endmodule

@@ rtl/core/compaction_relocation_table_top.sv @@
// Top level of the compaction relocation table.
//
//  channel   handshake              moves
//  --------  ---------------------  ------------------------------------------
//  request   push / full            req_type, first_round, full_pass,
//                                   heap_top, chunk_offset, chunk_size
//  result    pop / empty            result_kind, move_from, move_to, move_bytes,
//                                   map_found, last_result, new_top,
//                                   free_bytes, more_rounds
//  config    cfg_valid / cfg_ready  cfg_data (pool_bytes)
//
// A start request sets up the round and answers with an acknowledgement; a note
// reads and rewrites each entry it shifts; a close visits every table entry; a map
// visits the entries from the first moved entry up to the first not below the key.
// The table RAM has a single registered read port: each entry read feeds the next state.
// Reset is synchronous; no clearing pass, table entries are only read once written.
// A full result queue stalls the sequencer; the request queue keeps accepting until full.
module compaction_relocation_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic        first_round,
  input  logic        full_pass,
  input  logic [15:0] heap_top,
  input  logic [15:0] chunk_offset,
  input  logic [15:0] chunk_size,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind,
  output logic [15:0] move_from,
  output logic [15:0] move_to,
  output logic [15:0] move_bytes,
  output logic        map_found,
  output logic        last_result,
  output logic [15:0] new_top,
  output logic [15:0] free_bytes,
  output logic        more_rounds,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  crt_pkg::crt_req_t req;
  crt_pkg::crt_res_t res_in;
  crt_pkg::crt_res_t res_q;
  logic              req_valid;
  logic              take;
  logic              res_push;
  logic              res_full;
  logic [crt_pkg::RES_W-1:0] res_bits;

  assign cfg_ready = 1'b1;

  crt_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .req_type     (req_type),
    .first_round  (first_round),
    .full_pass    (full_pass),
    .heap_top     (heap_top),
    .chunk_offset (chunk_offset),
    .chunk_size   (chunk_size),
    .take         (take),
    .req_valid    (req_valid),
    .req          (req)
  );

  crt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .take      (take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_in)
  );

  crt_fifo #(
    .WIDTH (crt_pkg::RES_W),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

  // unpack the oldest result onto the ports
  assign res_q       = crt_pkg::crt_res_t'(res_bits);
  assign result_kind = res_q.result_kind;
  assign move_from   = res_q.move_from;
  assign move_to     = res_q.move_to;
  assign move_bytes  = res_q.move_bytes;
  assign map_found   = res_q.map_found;
  assign last_result = res_q.last_result;
  assign new_top     = res_q.new_top;
  assign free_bytes  = res_q.free_bytes;
  assign more_rounds = res_q.more_rounds;

endmodule

@@ bench/crt_relocation_checker.sv @@
// Relocation table checker: tracks table state, predicts results, compares them.
`timescale 1ns / 100ps
module crt_relocation_checker
  import crt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  req_type,
  input  logic        first_round,
  input  logic        full_pass,
  input  logic [15:0] heap_top,
  input  logic [15:0] chunk_offset,
  input  logic [15:0] chunk_size,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  result_kind,
  input  logic [15:0] move_from,
  input  logic [15:0] move_to,
  input  logic [15:0] move_bytes,
  input  logic        map_found,
  input  logic        last_result,
  input  logic [15:0] new_top,
  input  logic [15:0] free_bytes,
  input  logic        more_rounds,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  localparam int unsigned DEPTH = 64;

  // shadow copy of the table and window state
  logic [15:0] tbl_off [DEPTH];
  logic [15:0] tbl_val [DEPTH];
  int unsigned n_ent, first_mv;
  logic [15:0] win_lo, win_hi, run_top, full_top, pool;
  bit          pass_full, is_closed;
  crt_res_t    moves_due[$];
  int          res_seen;

  initial errors = 0;

  function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // lower bound over the moving part of the table
  function automatic int find_slot(input logic [15:0] key);
    int lo, hi, mid;
    lo = first_mv;
    hi = int'(n_ent) - 1;
    while (lo <= hi) begin
      mid = (lo + hi) >>> 1;
      if (tbl_off[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void add_result(input logic [1:0] kind, input logic [15:0] from,
                                     input logic [15:0] to, input logic [15:0] bytes,
                                     input logic found, input logic last,
                                     input logic [15:0] top, input logic [15:0] freeb,
                                     input logic more);
    crt_res_t r;
    r.result_kind = kind;
    r.move_from   = from;
    r.move_to     = to;
    r.move_bytes  = bytes;
    r.map_found   = found;
    r.last_result = last;
    r.new_top     = top;
    r.free_bytes  = freeb;
    r.more_rounds = more;
    moves_due.push_back(r);
  endfunction

  function automatic void shadow_insert(input logic [15:0] off, input logic [15:0] size);
    int pos, j;
    if (is_closed || off < win_lo || off >= win_hi) return;
    pos = find_slot(off);
    if (pos >= DEPTH) return;  // no slot past the end of a full table
    j = (n_ent < DEPTH) ? n_ent : DEPTH - 1;
    for (; j > pos; j--) begin
      tbl_off[j] = tbl_off[j-1];
      tbl_val[j] = tbl_val[j-1];
    end
    tbl_off[pos] = off;
    tbl_val[pos] = size;
    if (n_ent < DEPTH) n_ent++;
    if (n_ent == DEPTH) win_hi = add_sat(tbl_off[DEPTH-1], tbl_val[DEPTH-1]);
  endfunction

  function automatic void close_table();
    int unsigned i, n;
    logic [15:0] top, sz, freeb;
    bit more;
    n = 0;
    more = (n_ent == DEPTH);
    if (!is_closed) begin
      top = run_top;
      // chunks already in place stay put
      for (i = 0; i < n_ent; i++) begin
        if (tbl_off[i] > top) break;
        top = add_sat(top, tbl_val[i]);
      end
      first_mv = i;
      win_lo = (i < n_ent) ? tbl_off[i] : win_hi;
      for (; i < n_ent; i++) begin
        sz = tbl_val[i];
        tbl_val[i] = top;
        top = add_sat(top, sz);
        add_result(KIND_MOVE, tbl_off[i], tbl_val[i], sz, 1'b0, 1'b0, top, 16'd0, 1'b0);
        n++;
      end
      run_top = top;
      is_closed = 1'b1;
      if (!more && pass_full) full_top = top;
    end
    freeb = (run_top < pool) ? pool - run_top : 16'd0;
    if (n == 0) begin
      add_result(KIND_SUMMARY, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, run_top, freeb, more);
    end else begin
      moves_due[moves_due.size()-1].last_result = 1'b1;
      moves_due[moves_due.size()-1].free_bytes  = freeb;
      moves_due[moves_due.size()-1].more_rounds = more;
    end
  endfunction

  function automatic void predict_request();
    logic [15:0] to;
    logic found;
    int pos;
    case (req_op_t'(req_type))
      REQ_START: begin
        if (first_round) begin
          pass_full = full_pass || (full_top == 16'd0);
          run_top   = pass_full ? 16'd0 : full_top;
          win_lo    = run_top;
        end else begin
          win_lo = win_hi;
        end
        win_hi    = heap_top;
        n_ent     = 0;
        first_mv  = 0;
        is_closed = 1'b0;
        add_result(KIND_ACK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, run_top, 16'd0, 1'b0);
      end
      REQ_NOTE: begin
        shadow_insert(chunk_offset, chunk_size);
        add_result(KIND_ACK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, run_top, 16'd0, 1'b0);
      end
      REQ_CLOSE: close_table();
      default: begin
        to = chunk_offset;
        found = 1'b0;
        if (is_closed) begin
          if (chunk_offset < win_lo || chunk_offset >= win_hi) begin
            found = 1'b1;
          end else begin
            pos = find_slot(chunk_offset);
            if (pos < n_ent && tbl_off[pos] == chunk_offset) begin
              to = tbl_val[pos];
              found = 1'b1;
            end
          end
        end
        add_result(KIND_MAP, 16'd0, to, 16'd0, found, 1'b1, run_top, 16'd0, 1'b0);
      end
    endcase
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report($sformatf("result %0d %s got 0x%0h want 0x%0h", res_seen, name, got, want));
  endtask

  // compare results as they leave, then predict newly accepted requests
  always @(posedge clk) begin
    crt_res_t w;
    if (rst) begin
      n_ent = 0; first_mv = 0;
      win_lo = '0; win_hi = '0; run_top = '0; full_top = '0;
      pass_full = 1'b0; is_closed = 1'b0;
      pool = POOL_RESET;
      moves_due.delete();
      res_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) pool = cfg_data;
      if (pop && !empty) begin
        if (moves_due.size() == 0) begin
          report($sformatf("result %0d with no request pending", res_seen));
        end else begin
          w = moves_due.pop_front();
          check_field("result_kind", result_kind, w.result_kind);
          check_field("move_from", move_from, w.move_from);
          check_field("move_to", move_to, w.move_to);
          check_field("move_bytes", move_bytes, w.move_bytes);
          check_field("map_found", map_found, w.map_found);
          check_field("last_result", last_result, w.last_result);
          check_field("new_top", new_top, w.new_top);
          check_field("free_bytes", free_bytes, w.free_bytes);
          check_field("more_rounds", more_rounds, w.more_rounds);
        end
        res_seen++;
      end
      if (push && !full) predict_request();
    end
    pending = moves_due.size();
  end

endmodule

@@ bench/compaction_relocation_table_top_tb.sv @@
// Testbench top: clock, reset, request, result pop and config stimulus, and the verdict.
`timescale 1ns / 100ps
module compaction_relocation_table_top_tb;
  import crt_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 210;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  req_type = REQ_START;
  logic        first_round = 1'b0;
  logic        full_pass = 1'b0;
  logic [15:0] heap_top = '0;
  logic [15:0] chunk_offset = '0;
  logic [15:0] chunk_size = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  result_kind;
  logic [15:0] move_from, move_to, move_bytes, new_top, free_bytes;
  logic        map_found, last_result, more_rounds;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  int          errors, pending;
  int          stall_cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;       // no idling on either side
  logic [15:0] noted[$];          // offsets noted this round, for map hits

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  compaction_relocation_table_top u_top (.*);

  crt_relocation_checker u_chk (.*);

  // result side: pop with random idle cycles
  always @(posedge clk) pop <= !rst && (calm || $urandom_range(99) >= 8);

  // watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else
      stall_cycles <= stall_cycles + 1;
  end

  // one request; returns at the edge where it is taken, push still high
  task automatic send(input req_op_t op, input logic fr, input logic fp,
                      input logic [15:0] top, input logic [15:0] off,
                      input logic [15:0] size);
    bit took;
    while (!calm && $urandom_range(99) < 8) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    req_type     <= op;
    first_round  <= fr;
    full_pass    <= fp;
    heap_top     <= top;
    chunk_offset <= off;
    chunk_size   <= size;
    do begin
      @(negedge clk);
      took = !full;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  task automatic note(input logic [15:0] off, input logic [15:0] size);
    noted.push_back(off);
    send(REQ_NOTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
         16'($urandom_range(65535)), off, size);
  endtask

  task automatic start(input logic fr, input logic fp, input logic [15:0] top);
    noted.delete();
    send(REQ_START, fr, fp, top, 16'($urandom_range(65535)),
         16'($urandom_range(1, 65535)));
  endtask

  task automatic one_op(input req_op_t op, input logic [15:0] off);
    send(op, 1'($urandom_range(1)), 1'($urandom_range(1)), 16'($urandom_range(65535)),
         off, 16'($urandom_range(1, 65535)));
  endtask

  // idle the request side until every result is back and the sequencer is done
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (140) @(posedge clk);
  endtask

  task automatic write_pool(input logic [15:0] value);
    bit took;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int k, nmaps, rounds;
    logic [15:0] top, off;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_pool(16'hFFFF);

    // directed: corner cases of start, note, close and map
    start(1'b0, 1'b0, 16'd300);        // continuing start with nothing under way
    one_op(REQ_MAP, 16'd100);          // map before any close
    one_op(REQ_CLOSE, 16'd0);          // empty table
    start(1'b1, 1'b0, 16'd1000);       // incremental request forced to full
    note(16'd0, 16'd16);               // already in place
    note(16'd40, 16'd8);
    note(16'd200, 16'hFFFF);           // top saturates
    note(16'd2000, 16'd4);             // outside the window
    one_op(REQ_CLOSE, 16'd0);
    one_op(REQ_CLOSE, 16'd0);          // second close: summary only
    note(16'd60, 16'd4);               // after close: ignored
    one_op(REQ_MAP, 16'd40);
    one_op(REQ_MAP, 16'd41);           // unmatched
    one_op(REQ_MAP, 16'd0);            // below window
    one_op(REQ_MAP, 16'hFFFF);
    start(1'b1, 1'b0, 16'hFFFF);
    note(16'hFFFF, 16'hFFFF);
    start(1'b1, 1'b1, 16'd500);
    note(16'd0, 16'd10);
    note(16'd10, 16'd5);
    one_op(REQ_CLOSE, 16'd0);          // nothing moving, window emptied
    one_op(REQ_MAP, 16'd3);
    drain();
    write_pool(16'd4);

    // random rounds, mostly well formed
    rounds = 0;
    while (sent < RAND_ITEMS) begin
      calm = (rounds >= 8 && rounds < 12);
      if (rounds == 6) begin
        drain();
        write_pool(16'($urandom_range(4, 65535)));
      end else if (rounds == 14) begin
        drain();
        write_pool(POOL_RESET);
      end
      top = ($urandom_range(3) == 0) ? 16'($urandom_range(65535))
                                     : 16'($urandom_range(64, 4000));
      start($urandom_range(3) != 0, 1'($urandom_range(1)), top);
      k = (rounds == 3 || $urandom_range(15) == 0) ? 70 : $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(9) == 0) begin
          one_op(req_op_t'($urandom_range(3)), 16'($urandom_range(65535)));
        end else begin
          off = 16'($urandom_range(top));
          note(off, ($urandom_range(7) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(1, 64)));
        end
      end
      one_op(REQ_CLOSE, 16'd0);
      if ($urandom_range(5) == 0) one_op(REQ_CLOSE, 16'd0);
      nmaps = $urandom_range(4);
      for (int i = 0; i < nmaps; i++) begin
        if (noted.size() != 0 && $urandom_range(2) != 0)
          off = noted[$urandom_range(noted.size() - 1)];
        else
          off = 16'($urandom_range(65535));
        one_op(REQ_MAP, off);
      end
      // sometimes continue the collection with another round
      if ($urandom_range(2) == 0) begin
        start(1'b0, 1'($urandom_range(1)), 16'($urandom_range(65535)));
        for (int i = 0; i < 3; i++)
          note(16'($urandom_range(65535)), 16'($urandom_range(1, 64)));
        one_op(REQ_CLOSE, 16'd0);
      end
      rounds++;
    end
    calm = 1'b0;
    drain();

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/crt_pkg.sv
rtl/core/crt_ram.sv
rtl/core/crt_fifo.sv
rtl/core/crt_front.sv
rtl/core/crt_back.sv
rtl/core/compaction_relocation_table_top.sv
bench/crt_relocation_checker.sv
bench/compaction_relocation_table_top_tb.sv
